### design/multichannel_average_to_angle_top_assert.svh
// Assertion helpers used by the top-level design file.
`ifndef MULTICHANNEL_AVERAGE_TO_ANGLE_TOP_ASSERT_SVH
`define MULTICHANNEL_AVERAGE_TO_ANGLE_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define MATA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MATA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/mavg_pkg.sv
`timescale 1ns / 1ps

package mavg_pkg;

  localparam int SMP_W  = 10;  // converter sample and calibration limits
  localparam int CH_W   = 3;   // channel field
  localparam int ANG_W  = 8;   // angle registers and result
  localparam int DEN_W  = 10;  // divisor width of the serial divider
  localparam int PROD_W = 18;  // |avg - low| * |angle span| fits here
  localparam int MAP_W  = 20;  // signed mapped angle before clamping
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [SMP_W-1:0] CAL_MAX        = 10'd1023;
  localparam logic [ANG_W-1:0] ANGLE_LOW_RST  = 8'd0;
  localparam logic [ANG_W-1:0] ANGLE_HIGH_RST = 8'd180;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CALIB  = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    REG_ANGLE_LOW  = 1'b0,
    REG_ANGLE_HIGH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/mavg_in_if.sv
`timescale 1ns / 1ps

interface mavg_in_if;
  logic                           valid;
  logic                           ready;
  mavg_pkg::opcode_e              opcode;
  logic [mavg_pkg::CH_W-1:0]      channel;
  logic                           new_frame;
  logic [mavg_pkg::SMP_W-1:0]     sample;
  logic [mavg_pkg::SMP_W-1:0]     cal_low;
  logic [mavg_pkg::SMP_W-1:0]     cal_high;

  modport source (output valid, opcode, channel, new_frame, sample, cal_low, cal_high,
                  input ready);
  modport sink (input valid, opcode, channel, new_frame, sample, cal_low, cal_high,
                output ready);
endinterface

### design/mavg_out_if.sv
`timescale 1ns / 1ps

interface mavg_out_if;
  logic                           valid;
  logic                           ready;
  logic [mavg_pkg::CH_W-1:0]      out_channel;
  logic [mavg_pkg::SMP_W-1:0]     raw_value;
  logic [mavg_pkg::SMP_W-1:0]     average;
  logic [mavg_pkg::ANG_W-1:0]     angle;
  logic                           all_calibrated;

  modport source (output valid, out_channel, raw_value, average, angle, all_calibrated,
                  input ready);
  modport sink (input valid, out_channel, raw_value, average, angle, all_calibrated,
                output ready);
endinterface

### design/multichannel_average_to_angle_top.sv
// Multichannel moving average with a linear map onto an angle range.
// in_i carries requests: a converter sample for a channel, or a calibration
// write of that channel's low/high limits. Requests naming a channel at or
// above CHANNELS are dropped. A calibration write or a dropped request gives
// no result. A sample updates the channel's window and running sum and gives
// one result on out_o: channel, raw sample, truncated window average, mapped
// and clamped angle (zero when the channel's calibration is invalid), and the
// all-calibrated flag. It runs a bit-serial division of the sum by WINDOW, a
// shift-add multiply of up to 8 steps and a bit-serial division of the scaled
// offset by the calibration span; the two 18-step divisions share one divider
// and only the first runs for an invalid calibration. One sample is in work
// at a time, so the next request is taken only after the sample's result is
// loaded into the output register. That register holds a finished result
// while out_o.ready is low; the next sample is taken meanwhile, but its
// result waits until the register is free. After reset the window memory
// is swept to zero, one entry per cycle, with in_i.ready low; APB writes to
// angle_low (0x0) and angle_high (0x4) are taken at all times.
`timescale 1ns / 1ps
`include "multichannel_average_to_angle_top_assert.svh"

module multichannel_average_to_angle_top #(
  parameter int CHANNELS = 5,
  parameter int WINDOW   = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mavg_pkg::APB_AW-1:0]   paddr,
  input  logic [mavg_pkg::APB_DW-1:0]   pwdata,
  output logic [mavg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  mavg_in_if.sink                       in_i,
  mavg_out_if.source                    out_o
);

  localparam int SMP_W    = mavg_pkg::SMP_W;
  localparam int ANG_W    = mavg_pkg::ANG_W;
  localparam int CH_W     = mavg_pkg::CH_W;
  localparam int PROD_W   = mavg_pkg::PROD_W;
  localparam int DEN_W    = mavg_pkg::DEN_W;
  localparam int MAP_W    = mavg_pkg::MAP_W;
  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WP_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CI_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W    = SMP_W + $clog2(WINDOW);
  localparam int MCNT_W   = $clog2(ANG_W);
  localparam logic [WP_W-1:0]   WP_LAST  = WP_W'(WINDOW - 1);
  localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_DIVA,
    ST_MUL,
    ST_MGO,
    ST_DIVM,
    ST_CLAMP,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q, addr_q;
  logic [WP_W-1:0]     wp_q;
  logic [CI_W-1:0]     ch_q;
  logic [SMP_W-1:0]    smp_q, avg_q;
  logic [SUM_W-1:0]    sum_q [CHANNELS];
  logic [SMP_W-1:0]    cal_lo_q [CHANNELS];
  logic [SMP_W-1:0]    cal_hi_q [CHANNELS];
  logic [ANG_W-1:0]    alo_q, ahi_q;
  logic [PROD_W-1:0]   mcand_q, acc_q;
  logic [ANG_W-1:0]    mplier_q;
  logic [MCNT_W-1:0]   mcnt_q;
  logic                neg_q;
  logic [MAP_W-1:0]    map_q;
  logic [ANG_W-1:0]    angle_q;

  logic                out_valid_q, out_allcal_q;
  logic [CH_W-1:0]     out_ch_q;
  logic [SMP_W-1:0]    out_raw_q, out_avg_q;
  logic [ANG_W-1:0]    out_ang_q;

  logic                in_ready, in_take, ch_ok, cfg_we, all_cal, smp_take;
  logic [WP_W-1:0]     wp_next;
  logic [CI_W-1:0]     in_ch;
  logic [SMP_W-1:0]    ram_rdata, cur_lo, cur_hi;
  logic [SUM_W-1:0]    sum_new;
  logic [SMP_W:0]      diff_avg;
  logic [ANG_W:0]      diff_ang;
  logic [SMP_W-1:0]    mag_avg;
  logic [ANG_W-1:0]    mag_ang;
  logic [MAP_W-1:0]    quo_s, alo_s, ahi_s;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SMP_W-1:0]    ram_wdata;
  mavg_pkg::div_req_t  div_req;
  mavg_pkg::div_rsp_t  div_rsp;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (mavg_pkg::cfg_reg_e'(paddr[2]) == mavg_pkg::REG_ANGLE_HIGH)
                  ? mavg_pkg::APB_DW'(ahi_q) : mavg_pkg::APB_DW'(alo_q);

  // Input decode
  assign in_ready    = (state_q == ST_IDLE);
  assign in_i.ready  = in_ready;
  assign in_take     = in_i.valid && in_ready;
  assign ch_ok       = {1'b0, in_i.channel} < (CH_W + 1)'(CHANNELS);
  assign smp_take    = in_take && ch_ok && (in_i.opcode == mavg_pkg::OP_SAMPLE);
  assign in_ch       = CI_W'(in_i.channel);
  assign wp_next     = !in_i.new_frame ? wp_q : ((wp_q == WP_LAST) ? '0 : wp_q + 1'b1);

  assign cur_lo  = cal_lo_q[ch_q];
  assign cur_hi  = cal_hi_q[ch_q];
  assign sum_new = sum_q[ch_q] - SUM_W'(ram_rdata) + SUM_W'(smp_q);

  // Operands of the range map; products are formed on magnitudes
  always_comb begin
    diff_avg = {1'b0, avg_q} - {1'b0, cur_lo};
    diff_ang = {1'b0, ahi_q} - {1'b0, alo_q};
    mag_avg  = diff_avg[SMP_W] ? SMP_W'(-diff_avg) : diff_avg[SMP_W-1:0];
    mag_ang  = diff_ang[ANG_W] ? ANG_W'(-diff_ang) : diff_ang[ANG_W-1:0];
    quo_s    = MAP_W'(div_rsp.quotient);
    alo_s    = MAP_W'(alo_q);
    ahi_s    = MAP_W'(ahi_q);
  end

  always_comb begin
    all_cal = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (cal_hi_q[c] <= cal_lo_q[c]) begin
        all_cal = 1'b0;
      end
    end
  end

  // Shared serial divider: window average first, range map second
  always_comb begin
    div_req.start    = (state_q == ST_SUM) || (state_q == ST_MGO);
    div_req.dividend = (state_q == ST_SUM) ? PROD_W'(sum_new) : acc_q;
    div_req.divisor  = (state_q == ST_SUM) ? DEN_W'(WINDOW) : DEN_W'(cur_hi - cur_lo);
  end

  mavg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Window memory: swept to zero after reset, then read-modify-write per sample
  always_comb begin
    ram_we    = (state_q == ST_CLEAR) || (state_q == ST_SUM);
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
    ram_wdata = (state_q == ST_CLEAR) ? '0 : smp_q;
    ram_re    = (state_q == ST_RD);
  end

  mavg_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      addr_q       <= '0;
      wp_q         <= '0;
      ch_q         <= '0;
      smp_q        <= '0;
      avg_q        <= '0;
      alo_q        <= mavg_pkg::ANGLE_LOW_RST;
      ahi_q        <= mavg_pkg::ANGLE_HIGH_RST;
      mcand_q      <= '0;
      mplier_q     <= '0;
      acc_q        <= '0;
      mcnt_q       <= '0;
      neg_q        <= 1'b0;
      map_q        <= '0;
      angle_q      <= '0;
      out_valid_q  <= 1'b0;
      out_ch_q     <= '0;
      out_raw_q    <= '0;
      out_avg_q    <= '0;
      out_ang_q    <= '0;
      out_allcal_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c]    <= '0;
        cal_lo_q[c] <= '0;
        cal_hi_q[c] <= mavg_pkg::CAL_MAX;
      end
    end else begin
      if (cfg_we) begin
        if (mavg_pkg::cfg_reg_e'(paddr[2]) == mavg_pkg::REG_ANGLE_HIGH) begin
          ahi_q <= pwdata[ANG_W-1:0];
        end else begin
          alo_q <= pwdata[ANG_W-1:0];
        end
      end

      // A result loaded in the finish state replaces the one leaving
      if (out_valid_q && out_o.ready && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_END) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take && ch_ok) begin
            if (in_i.opcode == mavg_pkg::OP_CALIB) begin
              cal_lo_q[in_ch] <= in_i.cal_low;
              cal_hi_q[in_ch] <= in_i.cal_high;
            end else begin
              wp_q    <= wp_next;
              ch_q    <= in_ch;
              smp_q   <= in_i.sample;
              addr_q  <= ADDR_W'(int'(in_ch) * WINDOW + int'(wp_next));
              state_q <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum_q[ch_q] <= sum_new;
          state_q     <= ST_DIVA;
        end
        ST_DIVA: begin
          if (div_rsp.done) begin
            avg_q <= div_rsp.quotient[SMP_W-1:0];
            if (cur_hi > cur_lo) begin
              state_q <= ST_MUL;
            end else begin
              angle_q <= '0;
              state_q <= ST_FIN;
            end
          end
        end
        ST_MUL: begin
          // First cycle loads operands; avg_q is valid from here on
          if (mcnt_q == '0 && acc_q == '0 && mplier_q == '0 && mcand_q == '0) begin
            mcand_q  <= PROD_W'(mag_avg);
            mplier_q <= mag_ang;
            neg_q    <= diff_avg[SMP_W] ^ diff_ang[ANG_W];
            mcnt_q   <= MCNT_W'(1);
            acc_q    <= '0;
            if (mag_avg == '0 || mag_ang == '0) begin
              state_q <= ST_MGO;
            end
          end else begin
            if (mplier_q[0]) begin
              acc_q <= acc_q + mcand_q;
            end
            mcand_q  <= mcand_q << 1;
            mplier_q <= mplier_q >> 1;
            mcnt_q   <= mcnt_q + 1'b1;
            if (mplier_q[ANG_W-1:1] == '0) begin
              state_q <= ST_MGO;
            end
          end
        end
        ST_MGO: begin
          state_q <= ST_DIVM;
        end
        ST_DIVM: begin
          if (div_rsp.done) begin
            map_q   <= (neg_q ? -quo_s : quo_s) + alo_s;
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if ($signed(map_q) < $signed(alo_s)) begin
            angle_q <= (alo_s > ahi_s) ? ahi_q : alo_q;
          end else if ($signed(map_q) > $signed(ahi_s)) begin
            angle_q <= ahi_q;
          end else begin
            angle_q <= map_q[ANG_W-1:0];
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_ch_q     <= CH_W'(ch_q);
            out_raw_q    <= smp_q;
            out_avg_q    <= avg_q;
            out_ang_q    <= angle_q;
            out_allcal_q <= all_cal;
            mcand_q      <= '0;
            mplier_q     <= '0;
            acc_q        <= '0;
            mcnt_q       <= '0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_channel    = out_ch_q;
  assign out_o.raw_value      = out_raw_q;
  assign out_o.average        = out_avg_q;
  assign out_o.angle          = out_ang_q;
  assign out_o.all_calibrated = out_allcal_q;

  `MATA_ASSERT(a_div_start_idle, clk_i, rst_ni, div_req.start |-> !div_rsp.busy, "divider busy")
  `MATA_NEVER(a_wp_range, clk_i, rst_ni, wp_q > WP_LAST, "write position beyond window")
  `MATA_ASSERT(a_out_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_FIN, "bad load")
  `MATA_ASSERT(a_sample_reads, clk_i, rst_ni, smp_take |=> state_q == ST_RD, "sample not started")

endmodule

### design/mavg_ram.sv
`timescale 1ns / 1ps

module mavg_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 40
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mavg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module mavg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mavg_pkg::div_req_t req_i,
  output mavg_pkg::div_rsp_t rsp_o
);

  localparam int PW    = mavg_pkg::PROD_W;
  localparam int DW    = mavg_pkg::DEN_W;
  localparam int CNT_W = $clog2(PW + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    den_q, rem_q;
  logic [PW-1:0]    quo_q;
  logic [DW:0]      trial, diff;
  logic             fits;

  always_comb begin
    trial = {rem_q, quo_q[PW-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(PW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[PW-2:0], fits};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### tb/tb_multichannel_average_to_angle_top.sv
`timescale 1ns / 1ps

module tb_multichannel_average_to_angle_top;

  localparam int CHANNELS       = 5;
  localparam int WINDOW         = 8;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 322;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CH_W           = mavg_pkg::CH_W;
  localparam int SMP_W          = mavg_pkg::SMP_W;
  localparam int ANG_W          = mavg_pkg::ANG_W;
  localparam int APB_AW         = mavg_pkg::APB_AW;
  localparam int APB_DW         = mavg_pkg::APB_DW;

  typedef struct packed {
    mavg_pkg::opcode_e op;
    logic [CH_W-1:0]   ch;
    logic              nf;
    logic [SMP_W-1:0]  smp;
    logic [SMP_W-1:0]  clo;
    logic [SMP_W-1:0]  chi;
  } request_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] raw;
    logic [SMP_W-1:0] avg;
    logic [ANG_W-1:0] ang;
    logic             all_cal;
  } angle_result_t;

  class angle_scoreboard;
    logic [SMP_W-1:0] window_mem [CHANNELS][WINDOW];
    int               ch_sum [CHANNELS];
    int               slot;
    logic [SMP_W-1:0] cal_lo [CHANNELS];
    logic [SMP_W-1:0] cal_hi [CHANNELS];
    logic [ANG_W-1:0] ang_lo;
    logic [ANG_W-1:0] ang_hi;
    angle_result_t    pending_results [$];
    int               errors;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < WINDOW; k++) window_mem[c][k] = '0;
        ch_sum[c] = 0;
        cal_lo[c] = '0;
        cal_hi[c] = mavg_pkg::CAL_MAX;
      end
      slot   = 0;
      ang_lo = mavg_pkg::ANGLE_LOW_RST;
      ang_hi = mavg_pkg::ANGLE_HIGH_RST;
      errors = 0;
    endfunction

    function void write_register(mavg_pkg::cfg_reg_e r, logic [ANG_W-1:0] v);
      case (r)
        mavg_pkg::REG_ANGLE_LOW:  ang_lo = v;
        mavg_pkg::REG_ANGLE_HIGH: ang_hi = v;
        default: ;
      endcase
    endfunction

    function logic [ANG_W-1:0] angle_of(logic [SMP_W-1:0] avg, int c);
      int lo, hi, alo, ahi, m;
      lo  = int'(cal_lo[c]);
      hi  = int'(cal_hi[c]);
      alo = int'(ang_lo);
      ahi = int'(ang_hi);
      if (hi <= lo) return '0;
      // int division truncates toward zero
      m = (int'(avg) - lo) * (ahi - alo) / (hi - lo) + alo;
      if (m < alo) m = alo;
      if (m > ahi) m = ahi;
      return m[ANG_W-1:0];
    endfunction

    function void note_request(request_t rq);
      angle_result_t r;
      int            c;
      c = int'(rq.ch);
      if (c >= CHANNELS) return;
      if (rq.op == mavg_pkg::OP_CALIB) begin
        cal_lo[c] = rq.clo;
        cal_hi[c] = rq.chi;
        return;
      end
      if (rq.nf) slot = (slot + 1) % WINDOW;
      ch_sum[c] = ch_sum[c] - int'(window_mem[c][slot]) + int'(rq.smp);
      window_mem[c][slot] = rq.smp;
      r.ch      = rq.ch;
      r.raw     = rq.smp;
      r.avg     = SMP_W'(ch_sum[c] / WINDOW);
      r.ang     = angle_of(r.avg, c);
      r.all_cal = 1'b1;
      for (int k = 0; k < CHANNELS; k++)
        if (cal_hi[k] <= cal_lo[k]) r.all_cal = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(angle_result_t got);
      angle_result_t want;
      if (pending_results.size() == 0) begin
        $error("result on channel %0d with none outstanding", got.ch);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_channel", 16'(want.ch), 16'(got.ch));
      compare_field("raw_value", 16'(want.raw), 16'(got.raw));
      compare_field("average", 16'(want.avg), 16'(got.avg));
      compare_field("angle", 16'(want.ang), 16'(got.ang));
      compare_field("all_calibrated", 16'(want.all_cal), 16'(got.all_cal));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mavg_in_if  in_bus ();
  mavg_out_if out_bus ();

  angle_scoreboard sb;
  bit              idling_on = 1'b1;
  int              quiet_cycles = 0;

  multichannel_average_to_angle_top #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic apb_write(mavg_pkg::cfg_reg_e r, logic [ANG_W-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= APB_DW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.write_register(r, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_request(request_t rq);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= rq.op;
    in_bus.channel   <= rq.ch;
    in_bus.new_frame <= rq.nf;
    in_bus.sample    <= rq.smp;
    in_bus.cal_low   <= rq.clo;
    in_bus.cal_high  <= rq.chi;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sb.note_request(rq);
  endtask

  // Drop valid and hold until every outstanding result is back.
  task automatic settle(int tail);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  function automatic request_t make_request(mavg_pkg::opcode_e op, int c, bit nf, int smp,
                                            int clo, int chi);
    request_t rq;
    rq.op  = op;
    rq.ch  = CH_W'(c);
    rq.nf  = nf;
    rq.smp = SMP_W'(smp);
    rq.clo = SMP_W'(clo);
    rq.chi = SMP_W'(chi);
    return rq;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int       pick;
    int       lo;
    rq.op  = mavg_pkg::OP_SAMPLE;
    rq.ch  = CH_W'($urandom_range(0, CHANNELS - 1));
    rq.nf  = ($urandom_range(0, 4) == 0);
    rq.clo = SMP_W'($urandom);
    rq.chi = SMP_W'($urandom);
    case ($urandom_range(0, 3))
      0:       rq.smp = SMP_W'($urandom_range(0, 63));
      1:       rq.smp = SMP_W'($urandom_range(960, 1023));
      default: rq.smp = SMP_W'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      rq.op = mavg_pkg::OP_CALIB;
      // mostly well-formed ranges, so the all-calibrated flag keeps coming back
      if ($urandom_range(0, 3) != 0) begin
        lo     = $urandom_range(0, 1022);
        rq.clo = SMP_W'(lo);
        rq.chi = SMP_W'($urandom_range(lo + 1, 1023));
      end
    end else if (pick < 16) begin
      rq.op = mavg_pkg::opcode_e'($urandom_range(0, 1));
      rq.ch = CH_W'($urandom_range(CHANNELS, 7));
    end
    return rq;
  endfunction

  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_result({out_bus.out_channel, out_bus.raw_value, out_bus.average,
                       out_bus.angle, out_bus.all_calibrated});
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) || psel === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_multichannel_average_to_angle_top: done, errors");
      $finish;
    end
  end

  initial begin
    request_t directed [$];
    logic [ANG_W-1:0] lo_set;
    logic [ANG_W-1:0] hi_set;

    sb               = new();
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = mavg_pkg::OP_SAMPLE;
    in_bus.channel   = '0;
    in_bus.new_frame = 1'b0;
    in_bus.sample    = '0;
    in_bus.cal_low   = '0;
    in_bus.cal_high  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, dropped channels, bad calibration, clamps at both ends
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 0, 0, 1023, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 4, 1, 0, 1023, 1023));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 5, 0, 1023, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 7, 1, 512, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 6, 0, 0, 5, 10));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 1, 0, 0, 100, 900));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 1, 0, 500, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 1, 0, 0, 900, 1000));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 1, 0, 0, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 2, 0, 0, 500, 500));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 2, 0, 700, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 2, 0, 0, 1023, 0));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 2, 1, 1023, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 2, 0, 0, 0, 1023));
    for (int k = 0; k < 5; k++)
      directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 3, 1, 1023, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 3, 0, 1023, 0, 0));
    directed.push_back(make_request(mavg_pkg::OP_CALIB, 0, 0, 0, 0, 1));
    directed.push_back(make_request(mavg_pkg::OP_SAMPLE, 0, 0, 1023, 0, 0));
    foreach (directed[k]) send_request(directed[k]);

    // swapped angle limits
    settle(SETTLE_CYCLES);
    apb_write(mavg_pkg::REG_ANGLE_LOW, 8'd200);
    apb_write(mavg_pkg::REG_ANGLE_HIGH, 8'd40);
    send_request(make_request(mavg_pkg::OP_SAMPLE, 3, 0, 512, 0, 0));
    send_request(make_request(mavg_pkg::OP_SAMPLE, 1, 1, 100, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      settle(SETTLE_CYCLES);
      case (p)
        0: begin lo_set = 8'd0;   hi_set = 8'd255; end
        1: begin lo_set = 8'd255; hi_set = 8'd0;   end
        2: begin lo_set = 8'd0;   hi_set = 8'd0;   end
        3: begin lo_set = 8'd255; hi_set = 8'd255; end
        default: begin
          lo_set = ANG_W'($urandom_range(0, 127));
          hi_set = ANG_W'($urandom_range(128, 255));
        end
      endcase
      apb_write(mavg_pkg::REG_ANGLE_LOW, lo_set);
      apb_write(mavg_pkg::REG_ANGLE_HIGH, hi_set);
      idling_on = (p != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) settle(0);
        send_request(random_request());
      end
    end

    settle(100);
    if (sb.errors == 0)
      $display("tb_multichannel_average_to_angle_top: done, clean");
    else
      $display("tb_multichannel_average_to_angle_top: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mavg_pkg.sv
design/mavg_in_if.sv
design/mavg_out_if.sv
design/mavg_ram.sv
design/mavg_div.sv
design/multichannel_average_to_angle_top.sv
tb/tb_multichannel_average_to_angle_top.sv
